// ===== rtl/qpht_pkg.sv =====
// Shared constants and types of the quadratic-probe hash table.
// Used by the top level quadratic_probe_hash_table_unit; no dependencies.
package qpht_pkg;

   // Field widths of the item and result channels.
   localparam int OP_W      = 1;
   localparam int KEY_W     = 32;
   localparam int HASH_W    = 32;
   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int SLOT_W    = 6;
   localparam int CSR_W     = 7;

   // Parameter defaults.
   localparam int MAX_SLOTS_DEFAULT  = 64;
   localparam int KEY_BITS_DEFAULT   = 32;
   localparam int VALUE_BITS_DEFAULT = 32;

   // Table size after reset.
   localparam logic [CSR_W-1:0] TABLE_SIZE_RESET = CSR_W'(64);

   // The hash residue is built eight hash bits per cycle.
   localparam int HASH_BITS_PER_STEP = 8;
   localparam int HASH_STEPS         = HASH_W / HASH_BITS_PER_STEP;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NOT_FOUND = 2'd1;
   localparam status_type STATUS_FULL      = 2'd2;

   localparam logic [OP_W-1:0] OP_LOOKUP = 1'b0;
   localparam logic [OP_W-1:0] OP_INSERT = 1'b1;

endpackage

// ===== rtl/qpht_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module qpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/quadratic_probe_hash_table_unit.sv =====
// Open-addressing key/value table with quadratic probing, top level.
// Depends on qpht_pkg and qpht_ram.
// A new item is taken only in the idle state, once the last result has gone to the output register;
// the hash is first reduced modulo the table size in the hash state, then the slot RAM's single
// read port is visited once per probe.
// Reset is synchronous; afterwards a clearing pass empties every slot.
module quadratic_probe_hash_table_unit #(
   parameter int MAX_SLOTS  = qpht_pkg::MAX_SLOTS_DEFAULT,
   parameter int KEY_BITS   = qpht_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = qpht_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [qpht_pkg::OP_W-1:0]     req_operation,
   input  logic [qpht_pkg::KEY_W-1:0]    req_key_id,
   input  logic [qpht_pkg::HASH_W-1:0]   req_key_hash,
   input  logic [qpht_pkg::VALUE_W-1:0]  req_value,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [qpht_pkg::STATUS_W-1:0] rsp_status,
   output logic [qpht_pkg::VALUE_W-1:0]  rsp_value_out,
   output logic [qpht_pkg::SLOT_W-1:0]   rsp_slot,

   input  logic                          csr_wr_en,
   input  logic [qpht_pkg::CSR_W-1:0]    csr_wr_data
);

   import qpht_pkg::*;

   // Slot index width, and a count width that can also hold MAX_SLOTS itself.
   localparam int IDX_W   = $clog2(MAX_SLOTS);
   localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
   localparam int ENTRY_W = 1 + KEY_BITS + VALUE_BITS;
   localparam int HCNT_W  = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;

   // Sequencer states.
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HASH  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_PROBE = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CSR_W-1:0]      table_size_ff;
   logic [CNT_W-1:0]      used_slots;

   // Item being worked on.
   logic [OP_W-1:0]       op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [HASH_W-1:0]     hash_ff, hash_in;
   logic [HCNT_W-1:0]     hash_cnt_ff;
   logic [CNT_W-1:0]      rem_ff, rem_in;

   // Probe sequence: current slot, distance to the next slot, probe number.
   logic [IDX_W-1:0]      idx_ff, idx_in, idx_next;
   logic [IDX_W-1:0]      step_ff, step_next;
   logic [IDX_W-1:0]      probe_ff;
   logic [IDX_W-1:0]      clr_addr_ff;

   // Result waiting for the output register, and the output register.
   status_type            res_status_ff;
   logic [VALUE_W-1:0]    res_value_ff;
   logic [SLOT_W-1:0]     res_slot_ff;
   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [VALUE_W-1:0]    rsp_value_out_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;

   // Slot RAM ports.
   logic                  mem_wr_en;
   logic [IDX_W-1:0]      mem_wr_addr;
   logic [ENTRY_W-1:0]    mem_wr_data;
   logic [IDX_W-1:0]      mem_rd_addr;
   logic [ENTRY_W-1:0]    mem_rd_data;

   logic                  rd_used;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_value;

   logic                  hit_empty, hit_key, last_probe;
   logic                  finish;
   status_type            fin_status;
   logic [VALUE_W-1:0]    fin_value;
   logic [SLOT_W-1:0]     fin_slot;
   logic                  out_free;
   logic                  out_load;
   logic                  accept;

   // A size of zero acts as one, and a size beyond the table acts as the table size.
   always_comb begin
      if (table_size_ff == '0) begin
         used_slots = CNT_W'(1);
      end else if (int'(table_size_ff) > MAX_SLOTS) begin
         used_slots = CNT_W'(MAX_SLOTS);
      end else begin
         used_slots = CNT_W'(table_size_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RESET;
      end else if (csr_wr_en) begin
         table_size_ff <= csr_wr_data;
      end
   end

   // Hash residue, eight bits per cycle by restoring long division.
   always_comb begin
      logic [CNT_W:0] acc;
      acc = {1'b0, rem_ff};
      for (int b = 0; b < HASH_BITS_PER_STEP; b++) begin
         acc = {acc[CNT_W-1:0], hash_ff[HASH_W-1-b]};
         if (acc >= {1'b0, used_slots}) begin
            acc = acc - {1'b0, used_slots};
         end
      end
      rem_in  = acc[CNT_W-1:0];
      hash_in = hash_ff << HASH_BITS_PER_STEP;
   end

   // Consecutive squares differ by 2i+1, so the next slot is the current one plus
   // a step that itself grows by two, both kept below the table size.
   always_comb begin
      logic [CNT_W:0] sum;
      logic [CNT_W:0] s;
      sum = (CNT_W+1)'(idx_ff) + (CNT_W+1)'(step_ff);
      if (sum >= {1'b0, used_slots}) begin
         sum = sum - {1'b0, used_slots};
      end
      idx_next = sum[IDX_W-1:0];
      s = (CNT_W+1)'(step_ff) + (CNT_W+1)'(2);
      if (s >= {1'b0, used_slots}) begin
         s = s - {1'b0, used_slots};
      end
      if (s >= {1'b0, used_slots}) begin
         s = s - {1'b0, used_slots};
      end
      step_next = s[IDX_W-1:0];
   end

   // Decode of the slot read back from RAM.
   assign rd_used  = mem_rd_data[ENTRY_W-1];
   assign rd_key   = mem_rd_data[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
   assign rd_value = mem_rd_data[VALUE_BITS-1:0];

   assign hit_empty  = !rd_used;
   assign hit_key    = rd_used && (rd_key == key_ff);
   assign last_probe = (CNT_W'(probe_ff) + CNT_W'(1)) == used_slots;

   // Outcome of the current probe.
   always_comb begin
      finish     = 1'b0;
      fin_status = STATUS_OK;
      fin_value  = '0;
      fin_slot   = '0;
      if (hit_empty || hit_key) begin
         finish = 1'b1;
         if (op_ff == OP_INSERT) begin
            fin_slot = SLOT_W'(idx_ff);
         end else if (hit_key) begin
            fin_value = VALUE_W'(rd_value);
            fin_slot  = SLOT_W'(idx_ff);
         end else begin
            fin_status = STATUS_NOT_FOUND;
         end
      end else if (last_probe) begin
         finish     = 1'b1;
         fin_status = (op_ff == OP_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
      end
   end

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign out_load = out_free && ((state_ff == ST_PROBE && finish) || state_ff == ST_DONE);

   // RAM access: the clearing pass, an insert's write-back, and one read per probe.
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff;
      mem_wr_data = {1'b1, key_ff, val_ff};
      if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_addr_ff;
         mem_wr_data = '0;
      end else if (state_ff == ST_PROBE && op_ff == OP_INSERT && (hit_empty || hit_key)) begin
         mem_wr_en = 1'b1;
      end
      mem_rd_addr = (state_ff == ST_PROBE) ? idx_next : idx_ff;
   end

   qpht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == IDX_W'(MAX_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_cnt_ff == HCNT_W'(HASH_STEPS - 1)) begin
               state_in = ST_READ;
               idx_in   = rem_in[IDX_W-1:0];
            end
         end
         ST_READ: begin
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (finish) begin
               state_in = out_free ? ST_IDLE : ST_DONE;
            end else begin
               idx_in = idx_next;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + IDX_W'(1);
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (accept) begin
         op_ff       <= req_operation;
         key_ff      <= KEY_BITS'(req_key_id);
         val_ff      <= VALUE_BITS'(req_value);
         hash_ff     <= req_key_hash;
         hash_cnt_ff <= '0;
         rem_ff      <= '0;
         probe_ff    <= '0;
         step_ff     <= (used_slots == CNT_W'(1)) ? IDX_W'(0) : IDX_W'(1);
      end
      if (state_ff == ST_HASH) begin
         hash_ff     <= hash_in;
         rem_ff      <= rem_in;
         hash_cnt_ff <= hash_cnt_ff + HCNT_W'(1);
      end
      if (state_ff == ST_PROBE && !finish) begin
         step_ff  <= step_next;
         probe_ff <= probe_ff + IDX_W'(1);
      end
      if (state_ff == ST_PROBE && finish) begin
         res_status_ff <= fin_status;
         res_value_ff  <= fin_value;
         res_slot_ff   <= fin_slot;
      end
      if (out_load) begin
         if (state_ff == ST_DONE) begin
            rsp_status_ff    <= res_status_ff;
            rsp_value_out_ff <= res_value_ff;
            rsp_slot_ff      <= res_slot_ff;
         end else begin
            rsp_status_ff    <= fin_status;
            rsp_value_out_ff <= fin_value;
            rsp_slot_ff      <= fin_slot;
         end
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_out_ff;
   assign rsp_slot      = rsp_slot_ff;

   // A new result only appears at the end of a probe sequence or from the holding state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_PROBE || $past(state_ff) == ST_DONE))
      else $error("result appeared outside the probe or holding state");

   // The slot RAM is written only by the clearing pass or an insert.
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_CLEAR || (state_ff == ST_PROBE && op_ff == OP_INSERT)))
      else $error("slot RAM written outside clearing or insert");

   // A failed item reports slot zero and value zero.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |->
         (rsp_slot_ff == '0 && rsp_value_out_ff == '0))
      else $error("failed item carries a slot or a value");

   // An accepted item always starts the hash reduction next.
   a_accept_hash: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_HASH))
      else $error("accepted item did not enter the hash reduction");

endmodule
